// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

    // which trace sum won, and whether the winner was not positive
    typedef struct packed {
        logic       deg;
        logic [1:0] sel;
    } ctl_t;

    localparam logic [1:0] SEL_W = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;
    localparam logic [1:0] SEL_Z = 2'd3;

endpackage

// ===== rtl/rmq_front.sv =====
module rmq_front #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  in_m [9],
    output logic                 out_valid,
    output rmq_pkg::ctl_t        out_ctl,
    output logic [2*W-3:0]       out_rad,
    output logic signed [W:0]    out_num [3]
);
    import rmq_pkg::*;

    localparam int F  = W - 2;
    localparam int RW = 2 * W - 2;
    localparam logic signed [W+1:0] ONE_T = (W+2)'(1) << F;

    logic                v1_reg;
    logic signed [W+1:0] t_reg [4];
    logic signed [W:0]   d21_reg, d02_reg, d10_reg, s10_reg, s02_reg, s21_reg;

    logic                v2_reg;
    ctl_t                ctl_reg;
    logic [RW-1:0]       rad_reg;
    logic signed [W:0]   num_reg [3];

    logic signed [W+1:0] e00, e11, e22;
    logic [1:0]          sel_next;
    logic signed [W+1:0] tmax;
    logic                deg_next;

    always_comb begin
        e00 = (W+2)'(in_m[0]);
        e11 = (W+2)'(in_m[4]);
        e22 = (W+2)'(in_m[8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
        end
        if (ce) begin
            t_reg[0] <= ONE_T + e00 + e11 + e22;
            t_reg[1] <= ONE_T + e00 - e11 - e22;
            t_reg[2] <= ONE_T - e00 + e11 - e22;
            t_reg[3] <= ONE_T - e00 - e11 + e22;
            d21_reg  <= (W+1)'(in_m[7]) - (W+1)'(in_m[5]);
            d02_reg  <= (W+1)'(in_m[2]) - (W+1)'(in_m[6]);
            d10_reg  <= (W+1)'(in_m[3]) - (W+1)'(in_m[1]);
            s10_reg  <= (W+1)'(in_m[3]) + (W+1)'(in_m[1]);
            s02_reg  <= (W+1)'(in_m[2]) + (W+1)'(in_m[6]);
            s21_reg  <= (W+1)'(in_m[7]) + (W+1)'(in_m[5]);
        end
    end

    // largest trace, lowest index wins ties
    always_comb begin
        sel_next = SEL_W;
        tmax     = t_reg[0];
        if (t_reg[1] > tmax) begin
            sel_next = SEL_X;
            tmax     = t_reg[1];
        end
        if (t_reg[2] > tmax) begin
            sel_next = SEL_Y;
            tmax     = t_reg[2];
        end
        if (t_reg[3] > tmax) begin
            sel_next = SEL_Z;
            tmax     = t_reg[3];
        end
        deg_next = (tmax <= 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
        if (ce) begin
            ctl_reg.deg <= deg_next;
            ctl_reg.sel <= sel_next;
            rad_reg     <= deg_next ? '0 : (RW'(tmax[W:0]) << (F - 2));
            case (sel_next)
                SEL_W: begin
                    num_reg[0] <= d21_reg; num_reg[1] <= d02_reg; num_reg[2] <= d10_reg;
                end
                SEL_X: begin
                    num_reg[0] <= d21_reg; num_reg[1] <= s10_reg; num_reg[2] <= s02_reg;
                end
                SEL_Y: begin
                    num_reg[0] <= d02_reg; num_reg[1] <= s10_reg; num_reg[2] <= s21_reg;
                end
                default: begin
                    num_reg[0] <= d10_reg; num_reg[1] <= s02_reg; num_reg[2] <= s21_reg;
                end
            endcase
        end
    end

    assign out_valid = v2_reg;
    assign out_ctl   = ctl_reg;
    assign out_rad   = rad_reg;
    assign out_num   = num_reg;

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  rmq_pkg::ctl_t        in_ctl,
    input  logic [2*W-3:0]       in_rad,
    input  logic signed [W:0]    in_num [3],
    output logic                 out_valid,
    output rmq_pkg::ctl_t        out_ctl,
    output logic [W-1:0]         out_b,
    output logic signed [W:0]    out_num [3]
);
    import rmq_pkg::*;

    localparam int RW = 2 * W - 2;
    localparam int SB = W - 1;

    logic              v_reg    [SB+1];
    ctl_t              ctl_reg  [SB+1];
    logic [RW-1:0]     rem_reg  [SB+1];
    logic [SB-1:0]     root_reg [SB+1];
    logic signed [W:0] num_reg  [SB+1][3];

    logic              vo_reg;
    ctl_t              ctlo_reg;
    logic [W-1:0]      b_reg;
    logic signed [W:0] numo_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
        end
        if (ce) begin
            ctl_reg[0]  <= in_ctl;
            rem_reg[0]  <= in_rad;
            root_reg[0] <= '0;
            num_reg[0]  <= in_num;
        end
    end

    // one root bit per stage, most significant first
    for (genvar s = 0; s < SB; s++) begin : g_step
        localparam int K = SB - 1 - s;
        logic [RW-1:0] trial;
        logic          take;

        always_comb begin
            trial = (RW'(root_reg[s]) << (K + 1)) | (RW'(1) << (2 * K));
            take  = rem_reg[s] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s+1] <= 1'b0;
            end else if (ce) begin
                v_reg[s+1] <= v_reg[s];
            end
            if (ce) begin
                ctl_reg[s+1]  <= ctl_reg[s];
                rem_reg[s+1]  <= take ? rem_reg[s] - trial : rem_reg[s];
                root_reg[s+1] <= take ? (root_reg[s] | (SB'(1) << K)) : root_reg[s];
                num_reg[s+1]  <= num_reg[s];
            end
        end
    end

    // round to nearest: remainder is x - r*r
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ce) begin
            vo_reg <= v_reg[SB];
        end
        if (ce) begin
            ctlo_reg <= ctl_reg[SB];
            b_reg    <= (rem_reg[SB] > RW'(root_reg[SB])) ? W'(root_reg[SB]) + W'(1)
                                                          : W'(root_reg[SB]);
            numo_reg <= num_reg[SB];
        end
    end

    assign out_valid = vo_reg;
    assign out_ctl   = ctlo_reg;
    assign out_b     = b_reg;
    assign out_num   = numo_reg;

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  rmq_pkg::ctl_t        in_ctl,
    input  logic [W-1:0]         in_b,
    input  logic signed [W:0]    in_num [3],
    output logic                 out_valid,
    output rmq_pkg::ctl_t        out_ctl,
    output logic [W-1:0]         out_b,
    output logic                 out_neg [3],
    output logic                 out_ovf [3],
    output logic [W-2:0]         out_q [3]
);
    import rmq_pkg::*;

    localparam int F  = W - 2;
    localparam int NW = 2 * W;
    localparam int QB = F + 1;

    logic          v_reg   [QB+1];
    ctl_t          ctl_reg [QB+1];
    logic [W-1:0]  b_reg   [QB+1];
    logic          neg_reg [QB+1][3];
    logic          ovf_reg [QB+1][3];
    logic [NW-1:0] rem_reg [QB+1][3];
    logic [QB-1:0] q_reg   [QB+1][3];

    logic [W:0]    mag  [3];
    logic [NW-1:0] numr [3];
    logic [NW-1:0] lim;

    // magnitude scaled, plus half the divisor for rounding to nearest, ties away from zero
    always_comb begin
        lim = NW'(in_b) << QB;
        for (int l = 0; l < 3; l++) begin
            mag[l]  = in_num[l][W] ? (W+1)'(-in_num[l]) : (W+1)'(in_num[l]);
            numr[l] = (NW'(mag[l]) << (F - 2)) + NW'(in_b >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
        end
        if (ce) begin
            ctl_reg[0] <= in_ctl;
            b_reg[0]   <= in_b;
            for (int l = 0; l < 3; l++) begin
                neg_reg[0][l] <= in_num[l][W];
                ovf_reg[0][l] <= numr[l] >= lim;
                rem_reg[0][l] <= numr[l];
                q_reg[0][l]   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage on each lane
    for (genvar s = 0; s < QB; s++) begin : g_step
        localparam int K = QB - 1 - s;
        logic [NW-1:0] dv;
        logic          take [3];

        always_comb begin
            dv = NW'(b_reg[s]) << K;
            for (int l = 0; l < 3; l++) begin
                take[l] = rem_reg[s][l] >= dv;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s+1] <= 1'b0;
            end else if (ce) begin
                v_reg[s+1] <= v_reg[s];
            end
            if (ce) begin
                ctl_reg[s+1] <= ctl_reg[s];
                b_reg[s+1]   <= b_reg[s];
                for (int l = 0; l < 3; l++) begin
                    neg_reg[s+1][l] <= neg_reg[s][l];
                    ovf_reg[s+1][l] <= ovf_reg[s][l];
                    rem_reg[s+1][l] <= take[l] ? rem_reg[s][l] - dv : rem_reg[s][l];
                    q_reg[s+1][l]   <= take[l] ? (q_reg[s][l] | (QB'(1) << K)) : q_reg[s][l];
                end
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign out_ctl   = ctl_reg[QB];
    assign out_b     = b_reg[QB];
    assign out_neg   = neg_reg[QB];
    assign out_ovf   = ovf_reg[QB];
    assign out_q     = q_reg[QB];

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion by Shepperd's method. One 3x3 matrix of signed Q1.(W-2)
// entries arrives per request on s_tdata and the quaternion (w, x, y, z) leaves in the same
// format on m_tdata, saturated to plus or minus 1.0, with m_tuser set when the largest trace
// sum is not positive (all components are then zero). The block is a pipeline that takes one
// matrix every cycle while m_tready does not stall it; its stages are the trace and select
// stages, a load stage and one stage per root bit of the square root, one rounding stage,
// one stage per quotient bit of the three parallel dividers plus their set-up stage, and the
// output register. A stall on m_tready freezes the whole pipeline and drops s_tready in the
// same cycle.
module rotation_matrix_to_quaternion #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2, m_r2_c0, m_r2_c1, m_r2_c2
    input  logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    m_tdata,
    // degenerate
    output logic                                      m_tuser
);
    import rmq_pkg::*;

    localparam int W   = COMPONENT_WIDTH;
    localparam int F   = W - 2;
    localparam int ODW = ((4 * W + 7) / 8) * 8;
    localparam logic [F:0]   ONE_Q = (F+1)'(1) << F;
    localparam logic [W-1:0] ONE_C = W'(1) << F;

    logic              ce;
    logic signed [W-1:0] m_in [9];

    logic              fv;
    ctl_t              fctl;
    logic [2*W-3:0]    frad;
    logic signed [W:0] fnum [3];

    logic              sv;
    ctl_t              sctl;
    logic [W-1:0]      sb;
    logic signed [W:0] snum [3];

    logic              dv;
    ctl_t              dctl;
    logic [W-1:0]      db;
    logic              dneg [3];
    logic              dovf [3];
    logic [W-2:0]      dq   [3];

    logic [W-1:0]      big;
    logic [W-1:0]      comp [3];
    logic [W-1:0]      qo   [4];
    logic [ODW-1:0]    tdata_next;

    logic              tvalid_reg;
    logic [ODW-1:0]    tdata_reg;
    logic              tuser_reg;

    assign ce       = !tvalid_reg || m_tready;
    assign s_tready = ce;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m_in[i] = s_tdata[i*W +: W];
        end
    end

    rmq_front #(.W(W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_tvalid), .in_m(m_in),
        .out_valid(fv), .out_ctl(fctl), .out_rad(frad), .out_num(fnum)
    );

    rmq_sqrt #(.W(W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(fv), .in_ctl(fctl), .in_rad(frad), .in_num(fnum),
        .out_valid(sv), .out_ctl(sctl), .out_b(sb), .out_num(snum)
    );

    rmq_div #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(sv), .in_ctl(sctl), .in_b(sb), .in_num(snum),
        .out_valid(dv), .out_ctl(dctl), .out_b(db),
        .out_neg(dneg), .out_ovf(dovf), .out_q(dq)
    );

    // clamp, restore sign, slot the square-root term in at the winning index
    always_comb begin
        big = (db > ONE_C) ? ONE_C : db;
        for (int l = 0; l < 3; l++) begin
            comp[l] = (dovf[l] || (dq[l] > ONE_Q)) ? ONE_C : W'(dq[l]);
            if (dneg[l]) begin
                comp[l] = -comp[l];
            end
        end
        case (dctl.sel)
            SEL_W:   begin qo[0] = big;     qo[1] = comp[0]; qo[2] = comp[1]; qo[3] = comp[2]; end
            SEL_X:   begin qo[0] = comp[0]; qo[1] = big;     qo[2] = comp[1]; qo[3] = comp[2]; end
            SEL_Y:   begin qo[0] = comp[0]; qo[1] = comp[1]; qo[2] = big;     qo[3] = comp[2]; end
            default: begin qo[0] = comp[0]; qo[1] = comp[1]; qo[2] = comp[2]; qo[3] = big;     end
        endcase
        tdata_next = '0;
        if (!dctl.deg) begin
            for (int l = 0; l < 4; l++) begin
                tdata_next[l*W +: W] = qo[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (ce) begin
            tvalid_reg <= dv;
        end
        if (ce) begin
            tdata_reg <= tdata_next;
            tuser_reg <= dctl.deg;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with non-zero components");

    a_nondeg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata != '0)
        else $error("non-degenerate result with all components zero");

    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[W-1:0]) <= $signed(ONE_C))
                  && ($signed(m_tdata[W-1:0]) >= -$signed(ONE_C)))
        else $error("quat_w outside saturation range");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(tdata_reg) && $stable(dv))
        else $error("pipeline moved during a stall");

endmodule
